>>> rtl/matb_pkg.sv
// Shared constants, pipeline types and the masked adder bit cell for the A2B converter.
package matb_pkg;

   localparam int MAX_WIDTH  = 13;
   localparam int WIDTH_BITS = 4;
   localparam int RAND_BITS  = 64;
   localparam int SHIFT_BITS = WIDTH_BITS + 1;
   // bits [0, SPLIT) ripple in stage 2, bits [SPLIT, MAX_WIDTH) in stage 3
   localparam int SPLIT      = (MAX_WIDTH + 1) / 2;
   localparam int REQ_BITS   = ((2 * MAX_WIDTH + RAND_BITS + 7) / 8) * 8;
   localparam int RSP_BITS   = ((2 * MAX_WIDTH + 7) / 8) * 8;

   typedef logic [MAX_WIDTH-1:0]  word_type;
   typedef logic [WIDTH_BITS-1:0] width_type;

   // one request in flight: Boolean-masked operands, carry masks, partial sums
   typedef struct packed {
      word_type x0;
      word_type x1;
      word_type y0;
      word_type y1;
      word_type rm;     // rm[i] masks carry AND i
      word_type mask;   // low w bits set
      word_type b0;
      word_type b1;
      logic     c0;
      logic     c1;
   } work_type;

   typedef struct packed {
      logic s0;
      logic s1;
      logic c0;
      logic c1;
   } bit_res_type;

   function automatic width_type clamp_width(input width_type v);
      width_type r;
      if (v == '0) begin
         r = width_type'(1);
      end else if (v > width_type'(MAX_WIDTH)) begin
         r = width_type'(MAX_WIDTH);
      end else begin
         r = v;
      end
      return r;
   endfunction

   // One bit of the masked ripple adder. The first bit ANDs the operands directly;
   // later bits AND (x ^ y) with (x ^ carry) and fold x back in.
   function automatic bit_res_type add_bit(input logic first,
                                           input logic xa, input logic xb,
                                           input logic ya, input logic yb,
                                           input logic ca, input logic cb,
                                           input logic m);
      bit_res_type r;
      logic ta, tb, pa, pb, qa, qb, va, vb;
      ta = xa ^ ya;
      tb = xb ^ yb;
      r.s0 = ta ^ ca;
      r.s1 = tb ^ cb;
      pa = first ? xa : ta;
      pb = first ? xb : tb;
      qa = first ? ya : (xa ^ ca);
      qb = first ? yb : (xb ^ cb);
      va = (pa & qa) ^ m;
      vb = (pb & qb) ^ m ^ (pa & qb) ^ (pb & qa);
      r.c0 = first ? va : (va ^ xa);
      r.c1 = first ? vb : (vb ^ xb);
      return r;
   endfunction

endpackage

>>> rtl/masked_arith_to_bool_convert.sv
// Top level: three-stage pipelined first-order masked arithmetic-to-Boolean converter.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+-----------------------------------------
//   req     | in  | req_tvalid/req_tready | tdata: arith_share0, arith_share1, fresh_random
//   rsp     | out | rsp_tvalid/rsp_tready | tdata: bool_share0, bool_share1
//   csr     | in  | csr_wr_en             | csr_wr_data: width_in_use
//
// rsp_tvalid rises once the request has passed the three register stages (s1_ff,
// s2_ff and b0_ff/b1_ff); one request per cycle sustained while rsp_tready is
// high. Stage 1 masks the operands (variable shifts of the random word),
// stages 2 and 3 each ripple about half of the masked carry chain.
// reset (synchronous) empties the pipeline and sets the width to 13.
// A stall on rsp backs up stage by stage; a stage refills as soon as it moves on.
module masked_arith_to_bool_convert (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // [12:0] arith_share0, [25:13] arith_share1, [89:26] fresh_random, rest zero
   input  logic [matb_pkg::REQ_BITS-1:0] req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [12:0] bool_share0, [25:13] bool_share1, rest zero
   output logic [matb_pkg::RSP_BITS-1:0] rsp_tdata,
   input  logic                          csr_wr_en,
   input  logic [matb_pkg::WIDTH_BITS-1:0] csr_wr_data
);

   localparam int W = matb_pkg::MAX_WIDTH;

   matb_pkg::width_type csr_width_ff;

   logic               v1_ff, v2_ff, v3_ff;
   logic               en1, en2, en3;
   matb_pkg::work_type s1_ff, s1_in;
   matb_pkg::work_type s2_ff, s2_in;
   matb_pkg::word_type b0_ff, b1_ff, b0_in, b1_in;

   // input fields
   matb_pkg::word_type                 a0, a1;
   logic [matb_pkg::RAND_BITS-1:0]     rnd;
   logic [matb_pkg::RAND_BITS-1:0]     rnd_sh1, rnd_sh2;
   matb_pkg::word_type                 mask, rx, ry;

   assign a0  = req_tdata[W-1:0];
   assign a1  = req_tdata[2*W-1:W];
   assign rnd = req_tdata[2*W+matb_pkg::RAND_BITS-1:2*W];

   // width register, clamped on write
   always_ff @(posedge clock) begin
      if (reset) begin
         csr_width_ff <= matb_pkg::width_type'(matb_pkg::MAX_WIDTH);
      end else if (csr_wr_en) begin
         csr_width_ff <= matb_pkg::clamp_width(csr_wr_data);
      end
   end

   // stage advance: each stage loads when empty or when it drains downstream
   assign en3        = !v3_ff || rsp_tready;
   assign en2        = !v2_ff || en3;
   assign en1        = !v1_ff || en2;
   assign req_tready = en1;

   // stage 1: Boolean masking of both shares, pick carry mask bits
   always_comb begin
      mask    = matb_pkg::word_type'(({1'b0, {W{1'b0}}} | (W+1)'(1) << csr_width_ff) - (W+1)'(1));
      rnd_sh1 = rnd >> csr_width_ff;
      rnd_sh2 = rnd >> {csr_width_ff, 1'b0};
      rx      = rnd[W-1:0] & mask;
      ry      = rnd_sh1[W-1:0] & mask;
      s1_in.x0   = (a0 ^ rx) & mask;
      s1_in.x1   = rx;
      s1_in.y0   = (a1 ^ ry) & mask;
      s1_in.y1   = ry;
      s1_in.rm   = rnd_sh2[W-1:0];
      s1_in.mask = mask;
      s1_in.b0   = '0;
      s1_in.b1   = '0;
      s1_in.c0   = 1'b0;
      s1_in.c1   = 1'b0;
   end

   // stage 2: low bits of the masked ripple adder
   always_comb begin
      matb_pkg::bit_res_type r;
      s2_in = s1_ff;
      for (int i = 0; i < matb_pkg::SPLIT; i++) begin
         r = matb_pkg::add_bit(i == 0, s1_ff.x0[i], s1_ff.x1[i], s1_ff.y0[i], s1_ff.y1[i],
                               s2_in.c0, s2_in.c1, s1_ff.rm[i]);
         s2_in.b0[i] = r.s0;
         s2_in.b1[i] = r.s1;
         s2_in.c0    = r.c0;
         s2_in.c1    = r.c1;
      end
   end

   // stage 3: high bits, then clear everything at and above the width
   always_comb begin
      matb_pkg::bit_res_type r;
      logic                  ca, cb;
      matb_pkg::word_type    t0, t1;
      ca = s2_ff.c0;
      cb = s2_ff.c1;
      t0 = s2_ff.b0;
      t1 = s2_ff.b1;
      for (int i = matb_pkg::SPLIT; i < W; i++) begin
         r = matb_pkg::add_bit(1'b0, s2_ff.x0[i], s2_ff.x1[i], s2_ff.y0[i], s2_ff.y1[i],
                               ca, cb, s2_ff.rm[i]);
         t0[i] = r.s0;
         t1[i] = r.s1;
         ca    = r.c0;
         cb    = r.c1;
      end
      b0_in = t0 & s2_ff.mask;
      b1_in = t1 & s2_ff.mask;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_tvalid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
      if (en3) begin
         b0_ff <= b0_in;
         b1_ff <= b1_in;
      end
   end

   assign rsp_tvalid = v3_ff;
   assign rsp_tdata  = {(matb_pkg::RSP_BITS - 2*W)'(0), b1_ff, b0_ff};

   // width register never leaves its legal range
   a_width_range: assert property (@(posedge clock) disable iff (reset)
      csr_width_ff != '0 && csr_width_ff <= matb_pkg::width_type'(matb_pkg::MAX_WIDTH))
      else $error("width register out of range");

   // back pressure reaches the input only with the whole pipeline full
   a_full_on_stall: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff))
      else $error("request refused with an empty stage");

   // a blocked middle stage keeps its request
   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && !en3) |=> (v2_ff && $stable(s2_ff)))
      else $error("stage 2 request lost during stall");

   // result bits at and above the width are zero
   a_high_zero: assert property (@(posedge clock) disable iff (reset)
      (v2_ff && en3) |=> (((b0_ff | b1_ff) & ~$past(s2_ff.mask)) == '0))
      else $error("result bits above width not cleared");

endmodule

>>> verif/matb_share_checker.sv
// Checker for the A2B converter: tracks the width, predicts Boolean shares, compares responses.
module matb_share_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   // [12:0] arith_share0, [25:13] arith_share1, [89:26] fresh_random, rest zero
   input  logic [matb_pkg::REQ_BITS-1:0]   req_tdata,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [12:0] bool_share0, [25:13] bool_share1, rest zero
   input  logic [matb_pkg::RSP_BITS-1:0]   rsp_tdata,
   input  logic                            csr_wr_en,
   input  logic [matb_pkg::WIDTH_BITS-1:0] csr_wr_data,
   output int                              fail_count,
   output int                              pending
);

   typedef struct packed {
      matb_pkg::word_type b0;
      matb_pkg::word_type b1;
   } share_pair_type;

   share_pair_type      expected_shares[$];
   matb_pkg::width_type width_now = matb_pkg::width_type'(matb_pkg::MAX_WIDTH);
   int                  errors = 0;

   // two-share ripple adder over Boolean-masked operands, one carry mask bit per AND
   function automatic share_pair_type convert_shares(input matb_pkg::word_type a0,
                                                     input matb_pkg::word_type a1,
                                                     input logic [63:0] rnd,
                                                     input int unsigned w);
      share_pair_type r;
      logic [matb_pkg::MAX_WIDTH:0] span;
      matb_pkg::word_type mask, rx, ry, x0, x1, y0, y1;
      logic c0, c1, xa, xb, ya, yb, ta, tb, pa, pb, qa, qb, m, va, vb;
      int unsigned i;
      span = (matb_pkg::MAX_WIDTH+1)'(1) << w;
      mask = matb_pkg::word_type'(span - 1'b1);
      rx = rnd[matb_pkg::MAX_WIDTH-1:0] & mask;
      ry = matb_pkg::word_type'(rnd >> w) & mask;
      x0 = (a0 ^ rx) & mask;
      x1 = rx;
      y0 = (a1 ^ ry) & mask;
      y1 = ry;
      r  = '0;
      c0 = 1'b0;
      c1 = 1'b0;
      for (i = 0; i < w; i++) begin
         xa = x0[i];
         xb = x1[i];
         ya = y0[i];
         yb = y1[i];
         ta = xa ^ ya;
         tb = xb ^ yb;
         if (i == 0) begin
            r.b0[i] = ta;
            r.b1[i] = tb;
            m  = rnd[2*w];
            c0 = (xa & ya) ^ m;
            c1 = (xb & yb) ^ m ^ (xa & yb) ^ (xb & ya);
         end else begin
            r.b0[i] = ta ^ c0;
            r.b1[i] = tb ^ c1;
            // top bit needs no carry out
            if (i != w - 1) begin
               m  = rnd[2*w+i];
               pa = ta;
               pb = tb;
               qa = xa ^ c0;
               qb = xb ^ c1;
               va = (pa & qa) ^ m;
               vb = (pb & qb) ^ m ^ (pa & qb) ^ (pb & qa);
               c0 = va ^ xa;
               c1 = vb ^ xb;
            end
         end
      end
      return r;
   endfunction

   always @(posedge clock) begin
      share_pair_type got, want;
      if (reset) begin
         expected_shares.delete();
         width_now <= matb_pkg::width_type'(matb_pkg::MAX_WIDTH);
         pending   <= 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.b0 = rsp_tdata[12:0];
            got.b1 = rsp_tdata[25:13];
            if (expected_shares.size() == 0) begin
               $error("response 0x%h/0x%h with no request outstanding", got.b0, got.b1);
               errors++;
            end else begin
               want = expected_shares.pop_front();
               if (got.b0 !== want.b0) begin
                  $error("bool_share0: expected 0x%h, got 0x%h", want.b0, got.b0);
                  errors++;
               end
               if (got.b1 !== want.b1) begin
                  $error("bool_share1: expected 0x%h, got 0x%h", want.b1, got.b1);
                  errors++;
               end
               if (rsp_tdata[matb_pkg::RSP_BITS-1:26] !== '0) begin
                  $error("rsp_pad: expected 0x0, got 0x%h",
                         rsp_tdata[matb_pkg::RSP_BITS-1:26]);
                  errors++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_shares.push_back(convert_shares(req_tdata[12:0], req_tdata[25:13],
                                                     req_tdata[89:26], 32'(width_now)));
         end
         // zero saturates up to one bit, anything past the maximum saturates down
         if (csr_wr_en) begin
            if (csr_wr_data == '0) begin
               width_now <= matb_pkg::width_type'(1);
            end else if (csr_wr_data > matb_pkg::width_type'(matb_pkg::MAX_WIDTH)) begin
               width_now <= matb_pkg::width_type'(matb_pkg::MAX_WIDTH);
            end else begin
               width_now <= csr_wr_data;
            end
         end
         pending <= expected_shares.size();
      end
      fail_count <= errors;
   end

endmodule

>>> verif/tb_masked_arith_to_bool_convert.sv
// Testbench top for the A2B converter: clock, reset, request and response traffic, verdict.
module tb_masked_arith_to_bool_convert;

   // pipeline is 3 deep; pad the tail a little
   localparam int DRAIN_CYCLES = 8;
   // cycles with no handshake at all before the run is declared hung
   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_PER_PHASE = 135;
   localparam int PHASES = 10;
   // response count at which the receiver goes deaf for a while
   localparam int HOLD_AT     = 200;
   localparam int HOLD_CYCLES = 80;
   // widths written ahead of phases 1..7; 0, 14 and 15 hit the saturation paths
   localparam int unsigned WIDTH_PLAN[7] = '{0, 15, 1, 7, 14, 2, 12};

   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [matb_pkg::REQ_BITS-1:0]   req_tdata = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [matb_pkg::RSP_BITS-1:0]   rsp_tdata;
   logic                            csr_wr_en = 1'b0;
   logic [matb_pkg::WIDTH_BITS-1:0] csr_wr_data = '0;

   int fail_count;
   int pending;
   // both sides idle at random only while this is set
   bit idle_on = 1'b1;
   int rsp_seen = 0;
   bit hold_done = 1'b0;
   int quiet_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   masked_arith_to_bool_convert u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   matb_share_checker u_checker (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .fail_count (fail_count),
      .pending    (pending)
   );

   // Offer one request after a random gap and hold it until the block takes it.
   // Valid is only lowered when a gap follows, so back-to-back requests never
   // see a low/high pair in the same step.
   task automatic send_request(input matb_pkg::word_type a0, input matb_pkg::word_type a1,
                               input logic [63:0] rnd);
      int unsigned gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(matb_pkg::REQ_BITS-90){1'b0}}, rnd, a1, a0};
      do @(posedge clock); while (!req_tready);
   endtask

   // Sender stops and waits until every outstanding request has answered.
   // The first look is at the next edge, so a push at the current edge is seen.
   task automatic wait_for_results();
      do @(posedge clock); while (pending != 0);
   endtask

   // Receiver: random stall per response, one long deaf stretch so the pipe
   // backs up into the request side while the sender keeps offering.
   initial begin
      int unsigned stall;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (!hold_done && rsp_seen >= HOLD_AT) begin
            stall = HOLD_CYCLES;
            hold_done = 1'b1;
         end else begin
            stall = idle_on ? $urandom_range(0, 7) : 0;
         end
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         rsp_seen++;
      end
   end

   // Watchdog: any handshake on either channel keeps it quiet.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
         end
      end
   end

   initial begin
      int unsigned p, n, pick;
      matb_pkg::word_type a0, a1;
      logic [63:0] rnd;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      for (p = 0; p < PHASES; p++) begin
         // phase 0 runs at the reset width; later phases rewrite it while idle
         if (p != 0) begin
            wait_for_results();
            repeat (4) @(posedge clock);
            csr_wr_en   <= 1'b1;
            csr_wr_data <= (p <= 7) ? matb_pkg::width_type'(WIDTH_PLAN[p-1])
                                    : matb_pkg::width_type'($urandom_range(0, 15));
            @(posedge clock);
            csr_wr_en   <= 1'b0;
         end
         // every third phase runs with no idling on either side
         idle_on = (p % 3) != 2;

         if (p == 0) begin
            // full 13-bit width: extremes, wrap of the sum, long carry chains
            send_request('0, '0, '0);
            send_request('1, '1, '1);
            send_request('1, 13'd1, '0);
            send_request(13'd1, '1, '1);
            send_request(13'h1555, 13'h0AAA, 64'hAAAA_AAAA_AAAA_AAAA);
            send_request(13'h1000, 13'h1000, '0);
            send_request('1, '0, {$urandom, $urandom});
            send_request('0, '1, {$urandom, $urandom});
            send_request(matb_pkg::word_type'($urandom), matb_pkg::word_type'($urandom),
                         64'h5555_5555_5555_5555);
         end else if (p == 1) begin
            // width written as zero, so one bit: upper share bits must be
            // ignored and the lone carry AND mask must not leak into the result
            send_request('0, '0, '0);
            send_request(13'd1, 13'd1, '0);
            send_request('1, '1, '1);
            send_request(13'h1FFE, 13'h1FFE, 64'h4);
            send_request(13'd1, '0, 64'h2);
            send_request('0, 13'd1, 64'h5);
            send_request(13'd1, 13'd1, 64'h7);
         end

         for (n = 0; n < RANDOM_PER_PHASE; n++) begin
            // bias toward all-zero and all-one operands and random words
            pick = $urandom_range(0, 7);
            a0 = (pick == 0) ? '0 : (pick == 1) ? '1 : matb_pkg::word_type'($urandom);
            pick = $urandom_range(0, 7);
            a1 = (pick == 0) ? '0 : (pick == 1) ? '1 : matb_pkg::word_type'($urandom);
            pick = $urandom_range(0, 15);
            rnd = (pick == 0) ? '0 : (pick == 1) ? '1 : {$urandom, $urandom};
            send_request(a0, a1, rnd);
         end
         // sender pauses here until the block has answered everything
         req_tvalid <= 1'b0;
      end

      wait_for_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
